FILE: design/qbu_pkg.sv
`timescale 1ns / 1ps

package qbu_pkg;

    // Table geometry
    localparam int STATE_ENTRIES = 4096;
    localparam int ACTION_COUNT  = 3;
    localparam int TABLE_DEPTH   = STATE_ENTRIES * ACTION_COUNT;
    localparam int ADDR_W        = $clog2(TABLE_DEPTH);
    localparam int JCNT_W        = $clog2(ACTION_COUNT);

    // Field widths
    localparam int INDEX_W    = 12;
    localparam int ACTION_W   = 2;
    localparam int ANGLE_W    = 16;
    localparam int VALUE_W    = 32;
    localparam int REWARD_W   = 20;
    localparam int DISC_W     = 16;
    localparam int TOL_W      = 13;
    localparam int WORD_W     = VALUE_W + 1;  // valid bit on top of the value
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_TOL = 1'd1;

    localparam logic [DISC_W-1:0] DISCOUNT_RESET = 16'd58982;
    localparam logic [TOL_W-1:0]  GOAL_TOL_RESET = 13'd214;

    // Q12 constants
    localparam int TWO_PI_Q12  = 25736;
    localparam int HALF_PI_Q12 = 6434;
    localparam int BONUS_Q12   = 409600;
    localparam logic signed [VALUE_W-1:0] FLOOR_Q12 = -32'sd409595904;

    // Sequencer controls for the update datapath
    typedef struct packed {
        logic init;  // new item: reset running maximum
        logic cmp;   // table read data is valid this cycle
        logic mul;   // load the discount product
    } upd_ctl_t;

endpackage

FILE: design/q_table_bellman_update_top.sv
`timescale 1ns / 1ps

// Tabular Q-learning update for a cart-pole. Each transfer carries the current and next
// state keys, the chosen action and the raw Q12 pole/cart state; one result follows with the
// new table value, the reward and the done flag. The value table (12288 entries of 32 bits
// plus a valid bit) sits in one single-port RAM, so an item costs ACTION_COUNT reads, a
// compare state, a multiply state and one write, after the accept in the idle state. A new
// item is accepted while the previous result still waits in the output register. After
// reset the block sweeps the RAM to clear the valid bits, one entry per cycle, before it
// accepts the first item; configuration writes are taken at any time but are meant for
// when the block is idle.
module q_table_bellman_update_top
    import qbu_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic        [INDEX_W-1:0]   current_index,
    input  logic        [ACTION_W-1:0]  chosen_action,
    input  logic        [INDEX_W-1:0]   next_index,
    input  logic signed [ANGLE_W-1:0]   pole_angle,
    input  logic signed [ANGLE_W-1:0]   pole_rate,
    input  logic signed [ANGLE_W-1:0]   cart_speed,
    input  logic signed [ANGLE_W-1:0]   cart_place,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [VALUE_W-1:0]   updated_value,
    output logic signed [REWARD_W-1:0]  step_reward,
    output logic                        episode_done,
    input  logic                        cfg_we,
    input  logic        [CFG_IDX_W-1:0] cfg_index,
    input  logic        [CFG_DATA_W-1:0] cfg_wdata
);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_READ  = 6'b000100,
        ST_CMP   = 6'b001000,
        ST_MUL   = 6'b010000,
        ST_WRITE = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [DISC_W-1:0] discount_reg;
    logic [TOL_W-1:0]  goal_tol_reg;

    logic        [INDEX_W-1:0]  cur_reg;
    logic        [ACTION_W-1:0] act_reg;
    logic        [INDEX_W-1:0]  next_reg;
    logic signed [ANGLE_W-1:0]  angle_reg;
    logic signed [ANGLE_W-1:0]  rate_reg;
    logic signed [ANGLE_W-1:0]  speed_reg;
    logic signed [ANGLE_W-1:0]  place_reg;

    logic [JCNT_W-1:0] j_reg;
    logic [JCNT_W-1:0] j_next;
    logic [ADDR_W-1:0] clr_reg;
    logic [ADDR_W-1:0] clr_next;
    logic              rd_pending_reg;

    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_addr;
    logic [WORD_W-1:0]    mem_wdata;
    logic [WORD_W-1:0]    mem_rdata;
    logic [ADDR_W-1:0]    rd_addr;
    logic [ADDR_W-1:0]    wr_addr;
    logic                 act_ok;
    logic                 accept;
    logic                 wr_go;
    upd_ctl_t             upd_ctl;

    logic signed [REWARD_W-1:0] reward;
    logic                       done;
    logic signed [VALUE_W-1:0]  total;

    logic                       out_valid_reg;
    logic signed [VALUE_W-1:0]  value_out_reg;
    logic signed [REWARD_W-1:0] reward_out_reg;
    logic                       done_out_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            discount_reg <= DISCOUNT_RESET;
            goal_tol_reg <= GOAL_TOL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DISCOUNT: discount_reg <= cfg_wdata[DISC_W-1:0];
                CFG_GOAL_TOL: goal_tol_reg <= cfg_wdata[TOL_W-1:0];
                default:      ;
            endcase
        end
    end

    assign accept  = in_valid && in_ready;
    assign act_ok  = 32'(act_reg) < ACTION_COUNT;
    assign rd_addr = ADDR_W'(next_reg) * ADDR_W'(ACTION_COUNT) + ADDR_W'(j_reg);
    assign wr_addr = ADDR_W'(cur_reg) * ADDR_W'(ACTION_COUNT) + ADDR_W'(act_reg);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        j_next     = j_reg;
        clr_next   = clr_reg;
        mem_we     = 1'b0;
        mem_addr   = rd_addr;
        mem_wdata  = '0;
        in_ready   = 1'b0;
        wr_go      = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_addr = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(TABLE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    j_next     = '0;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                j_next = j_reg + 1'b1;
                if (j_reg == JCNT_W'(ACTION_COUNT - 1))
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                mem_addr  = wr_addr;
                mem_wdata = {1'b1, total};
                // wait until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    wr_go      = 1'b1;
                    mem_we     = act_ok;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            j_reg          <= '0;
            clr_reg        <= '0;
            rd_pending_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            j_reg          <= j_next;
            clr_reg        <= clr_next;
            rd_pending_reg <= (state_reg == ST_READ);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_reg   <= current_index;
            act_reg   <= chosen_action;
            next_reg  <= next_index;
            angle_reg <= pole_angle;
            rate_reg  <= pole_rate;
            speed_reg <= cart_speed;
            place_reg <= cart_place;
        end
    end

    qbu_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    qbu_reward u_reward (
        .clk            (clk),
        .pole_angle     (angle_reg),
        .pole_rate      (rate_reg),
        .cart_speed     (speed_reg),
        .cart_place     (place_reg),
        .goal_tolerance (goal_tol_reg),
        .reward         (reward),
        .done           (done)
    );

    assign upd_ctl.init = accept;
    assign upd_ctl.cmp  = rd_pending_reg;
    assign upd_ctl.mul  = (state_reg == ST_MUL);

    qbu_update u_update (
        .clk      (clk),
        .ctl      (upd_ctl),
        .rdata    (mem_rdata),
        .discount (discount_reg),
        .reward   (reward),
        .total    (total)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (wr_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_go)
        begin
            value_out_reg  <= total;
            reward_out_reg <= reward;
            done_out_reg   <= done;
        end
    end

    assign out_valid     = out_valid_reg;
    assign updated_value = value_out_reg;
    assign step_reward   = reward_out_reg;
    assign episode_done  = done_out_reg;

`ifndef NO_ASSERTIONS
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_cmp_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CMP |-> rd_pending_reg && $past(state_reg == ST_READ))
        else $error("last table read not pending at compare");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE && out_valid_reg && !out_ready)
        |=> (state_reg == ST_WRITE && out_valid_reg))
        else $error("write went ahead over an untaken result");

    a_write_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        wr_go |=> (state_reg == ST_IDLE && out_valid_reg))
        else $error("result transfer not presented after write");
`endif

endmodule

FILE: design/qbu_ram.sv
`timescale 1ns / 1ps

module qbu_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 12288
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/qbu_reward.sv
`timescale 1ns / 1ps

module qbu_reward
    import qbu_pkg::*;
(
    input  logic                       clk,
    input  logic signed [ANGLE_W-1:0]  pole_angle,
    input  logic signed [ANGLE_W-1:0]  pole_rate,
    input  logic signed [ANGLE_W-1:0]  cart_speed,
    input  logic signed [ANGLE_W-1:0]  cart_place,
    input  logic        [TOL_W-1:0]    goal_tolerance,
    output logic signed [REWARD_W-1:0] reward,
    output logic                       done
);

    localparam logic signed [17:0] TWO_PI  = 18'(TWO_PI_Q12);
    localparam logic signed [15:0] HALF_PI = 16'(HALF_PI_Q12);
    localparam logic signed [REWARD_W-1:0] BONUS = REWARD_W'(BONUS_Q12);

    function automatic logic [16:0] abs17(input logic signed [15:0] v);
        logic signed [16:0] e;
        e = {v[15], v};
        return e[16] ? 17'(-e) : 17'(e);
    endfunction

    // stage 1: wrap angle into [0, 2pi), absolute values
    logic signed [17:0] ang_ext;
    logic signed [17:0] ang_sub;
    logic signed [17:0] ang_add1;
    logic signed [17:0] ang_add2;
    logic        [14:0] wrap_next;
    logic        [14:0] wrap_reg;
    logic        [16:0] rate_abs_reg;
    logic        [16:0] speed_abs_reg;
    logic        [16:0] place_abs_reg;

    always_comb
    begin
        ang_ext  = {{2{pole_angle[15]}}, pole_angle};
        ang_sub  = ang_ext - TWO_PI;
        ang_add1 = ang_ext + TWO_PI;
        ang_add2 = ang_add1 + TWO_PI;
        if (!ang_sub[17])
        begin
            wrap_next = ang_sub[14:0];
        end
        else if (!ang_ext[17])
        begin
            wrap_next = ang_ext[14:0];
        end
        else if (!ang_add1[17])
        begin
            wrap_next = ang_add1[14:0];
        end
        else
        begin
            wrap_next = ang_add2[14:0];
        end
    end

    always_ff @(posedge clk)
    begin
        wrap_reg      <= wrap_next;
        rate_abs_reg  <= abs17(pole_rate);
        speed_abs_reg <= abs17(cart_speed);
        place_abs_reg <= abs17(cart_place);
    end

    // stage 2: distance sum, goal band, bonus
    logic signed [15:0]         wrap_s;
    logic signed [15:0]         band_lo;
    logic signed [15:0]         band_hi;
    logic        [18:0]         dist_sum;
    logic                       done_next;
    logic signed [REWARD_W-1:0] reward_next;
    logic signed [REWARD_W-1:0] reward_reg;
    logic                       done_reg;

    always_comb
    begin
        wrap_s    = {1'b0, wrap_reg};
        band_lo   = HALF_PI - signed'({3'b000, goal_tolerance});
        band_hi   = HALF_PI + signed'({3'b000, goal_tolerance});
        dist_sum  = 19'(abs17(wrap_s - HALF_PI)) + 19'(rate_abs_reg)
                  + 19'(speed_abs_reg) + 19'(place_abs_reg);
        done_next = (wrap_s > band_lo) && (wrap_s < band_hi);
        reward_next = (done_next ? BONUS : '0) - signed'(REWARD_W'(dist_sum));
    end

    always_ff @(posedge clk)
    begin
        reward_reg <= reward_next;
        done_reg   <= done_next;
    end

    assign reward = reward_reg;
    assign done   = done_reg;

endmodule

FILE: design/qbu_update.sv
`timescale 1ns / 1ps

module qbu_update
    import qbu_pkg::*;
(
    input  logic                       clk,
    input  upd_ctl_t                   ctl,
    input  logic        [WORD_W-1:0]   rdata,
    input  logic        [DISC_W-1:0]   discount,
    input  logic signed [REWARD_W-1:0] reward,
    output logic signed [VALUE_W-1:0]  total
);

    localparam int PROD_W = VALUE_W + DISC_W + 1;
    localparam int SUM_W  = PROD_W + 1;
    localparam int SC_W   = SUM_W - 16;
    localparam logic signed [SC_W-1:0] SAT_MAX = SC_W'(64'sd2147483647);
    localparam logic signed [SC_W-1:0] SAT_MIN = SC_W'(-64'sd2147483648);

    logic signed [VALUE_W-1:0] rd_value;
    logic                      rd_valid;
    logic signed [VALUE_W-1:0] best_reg;
    logic signed [VALUE_W-1:0] best_next;
    logic signed [DISC_W:0]    disc_s;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [SUM_W-1:0]   sum;
    logic signed [SC_W-1:0]    scaled;

    assign rd_value = signed'(rdata[VALUE_W-1:0]);
    assign rd_valid = rdata[VALUE_W];
    assign disc_s   = signed'({1'b0, discount});

    // running maximum over the next state's actions, floor included
    always_comb
    begin
        best_next = best_reg;
        if (ctl.init)
        begin
            best_next = FLOOR_Q12;
        end
        else if (ctl.cmp && rd_valid && (rd_value > best_reg))
        begin
            best_next = rd_value;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
        if (ctl.mul)
        begin
            prod_reg <= best_reg * disc_s;
        end
    end

    // reward * 2^16 + half LSB folded into one add, then shift and clamp
    always_comb
    begin
        sum    = SUM_W'(prod_reg) + SUM_W'(signed'({reward, 16'h8000}));
        scaled = sum[SUM_W-1:16];
        if (scaled > SAT_MAX)
        begin
            total = SAT_MAX[VALUE_W-1:0];
        end
        else if (scaled < SAT_MIN)
        begin
            total = SAT_MIN[VALUE_W-1:0];
        end
        else
        begin
            total = scaled[VALUE_W-1:0];
        end
    end

endmodule
